### rtl/msb_pkg.sv
// msb_pkg: shared types and constants for the merge sort buffer.
// Beat structs for the command and result ports, cell control, FSM states.
// No dependencies.
`default_nettype none

package msb_pkg;

    localparam int MSB_MAX_ITEMS = 64;
    localparam int MSB_KEY_BITS  = 32;

    typedef struct packed {
        logic signed [31:0] key_in;
        logic               last_in;
    } msb_in_beat_t;

    typedef struct packed {
        logic signed [31:0] key_out;
        logic               last_out;
        logic               overflow;
    } msb_out_beat_t;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic load;   // insert the new key into the sorted row
        logic shift;  // move every key one cell toward cell 0
    } msb_ctl_t;

    typedef enum logic {
        MSB_LOAD,
        MSB_EMIT
    } msb_state_t;

endpackage : msb_pkg

`default_nettype wire

### rtl/merge_sort_buffer.sv
// merge_sort_buffer: top level; sorts a set of signed keys and bursts them out.
// Depends on msb_pkg and msb_cell.
`default_nettype none

// Usage
//   Command side: a key beat (item.key_in, item.last_in) is taken at a clock
//   edge with start high and busy low. Keys of one set arrive one per cycle,
//   back to back if wanted; the beat with last_in set closes the set.
//   Storage is a row of MAX_ITEMS cells kept in ascending order: every key is
//   inserted in the cycle it is taken, each cell either keeping its key,
//   taking its left neighbor's key or taking the new key. Keys past
//   MAX_ITEMS in one set are dropped and the set is flagged.
//   Result side: the cycle after the closing beat, busy rises and the set
//   streams out, smallest first, one beat per cycle with strobe high, while
//   the row shifts toward cell 0; last_out marks the greatest key and
//   overflow is set on every beat of a set that lost keys. busy falls
//   after the last beat, the row being empty.
//   No key is taken while a set streams out; loading and emitting do not overlap.
//   The receiver cannot stall; each result beat is valid for one cycle only.
//   Keys are held at KEY_BITS bits (wrapped from 32) and sign-extended back.
//   Reset (rst_n low, asynchronous) empties the row, clears the count and
//   the overflow flag and returns to loading.

module merge_sort_buffer #(
    parameter int MAX_ITEMS = msb_pkg::MSB_MAX_ITEMS,
    parameter int KEY_BITS  = msb_pkg::MSB_KEY_BITS
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    start,
    output logic                   busy,
    input  msb_pkg::msb_in_beat_t  item,
    output logic                   strobe,
    output msb_pkg::msb_out_beat_t result
);
    import msb_pkg::*;

    localparam int CNT_BITS = $clog2(MAX_ITEMS + 1);

    msb_state_t          state_reg, state_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                ovf_reg, ovf_next;

    msb_ctl_t                   ctl;
    logic                       accept;
    logic                       full;
    logic signed [KEY_BITS-1:0] key_new;

    logic signed [KEY_BITS-1:0] key_w   [MAX_ITEMS];
    logic                       valid_w [MAX_ITEMS];
    logic                       take_w  [MAX_ITEMS];

    assign key_new = KEY_BITS'($signed(item.key_in));
    assign full    = (count_reg == CNT_BITS'(MAX_ITEMS));
    assign accept  = start && (state_reg == MSB_LOAD);

    // ---------------- control FSM ----------------
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        ctl.load   = 1'b0;
        ctl.shift  = 1'b0;
        case (state_reg)
            MSB_LOAD:
            begin
                if (accept)
                begin
                    if (full)
                        ovf_next = 1'b1;
                    else
                    begin
                        ctl.load   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (item.last_in)
                        state_next = MSB_EMIT;
                end
            end
            MSB_EMIT:
            begin
                ctl.shift  = 1'b1;
                count_next = count_reg - 1'b1;
                if (count_reg == CNT_BITS'(1))
                begin
                    state_next = MSB_LOAD;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = MSB_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MSB_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // ---------------- cell chain ----------------
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        logic signed [KEY_BITS-1:0] prev_key, next_key;
        logic                       prev_take, prev_valid, next_valid;

        if (i == 0)
        begin : g_head
            assign prev_key   = '0;
            assign prev_take  = 1'b0;
            assign prev_valid = 1'b0;
        end
        else
        begin : g_body
            assign prev_key   = key_w[i-1];
            assign prev_take  = take_w[i-1];
            assign prev_valid = valid_w[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_tail
            assign next_key   = '0;
            assign next_valid = 1'b0;
        end
        else
        begin : g_link
            assign next_key   = key_w[i+1];
            assign next_valid = valid_w[i+1];
        end

        msb_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .key_new    (key_new),
            .prev_take  (prev_take),
            .prev_key   (prev_key),
            .prev_valid (prev_valid),
            .next_key   (next_key),
            .next_valid (next_valid),
            .key_q      (key_w[i]),
            .valid_q    (valid_w[i]),
            .take       (take_w[i])
        );
    end

    // ---------------- result port ----------------
    assign busy            = (state_reg == MSB_EMIT);
    assign strobe          = (state_reg == MSB_EMIT);
    assign result.key_out  = 32'($signed(key_w[0]));
    assign result.last_out = (count_reg == CNT_BITS'(1));
    assign result.overflow = ovf_reg;

    // ---------------- assertions ----------------
    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> valid_w[0])
        else $error("result beat from an empty head cell");

    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last_out |=> strobe)
        else $error("burst ended before the last beat");

    a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last_out |=> !busy && !valid_w[0])
        else $error("row not empty after last beat");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last_out |-> valid_w[1] && (key_w[0] <= key_w[1]))
        else $error("keys leave out of order");

endmodule : merge_sort_buffer

`default_nettype wire

### rtl/msb_cell.sv
// msb_cell: one slot of the sorted chain; holds a key and its valid bit.
// Depends on msb_pkg (msb_ctl_t).
`default_nettype none

module msb_cell #(
    parameter int KEY_BITS = msb_pkg::MSB_KEY_BITS
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  msb_pkg::msb_ctl_t          ctl,
    input  wire logic signed [KEY_BITS-1:0] key_new,
    input  wire logic                  prev_take,
    input  wire logic signed [KEY_BITS-1:0] prev_key,
    input  wire logic                  prev_valid,
    input  wire logic signed [KEY_BITS-1:0] next_key,
    input  wire logic                  next_valid,
    output logic signed [KEY_BITS-1:0] key_q,
    output logic                       valid_q,
    output logic                       take
);
    import msb_pkg::*;

    logic signed [KEY_BITS-1:0] key_reg, key_next;
    logic                       valid_reg, valid_next;

    // new key belongs at or before this slot
    assign take = !valid_reg || (key_reg > key_new);

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctl.load && take)
        begin
            // shifted-in slot inherits the neighbor's valid; empty tail stays empty
            key_next   = prev_take ? prev_key : key_new;
            valid_next = prev_take ? prev_valid : 1'b1;
        end
        else if (ctl.shift)
        begin
            key_next   = next_key;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key_q   = key_reg;
    assign valid_q = valid_reg;

endmodule : msb_cell

`default_nettype wire

### verif/tb_merge_sort_buffer.sv
// tb_merge_sort_buffer: self-checking testbench for merge_sort_buffer.
// Sends key sets, predicts the sorted burst in a scoreboard queue, checks every beat.
// Depends on msb_pkg and the merge_sort_buffer RTL.
`default_nettype none

module tb_merge_sort_buffer;
    import msb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
    localparam int MAX_GAP        = 60;    // longest sender idle stretch
    localparam int MAX_REPORTS    = 30;    // mismatch lines printed before going quiet

    logic          clk    = 1'b0;
    logic          rst_n  = 1'b0;
    logic          start  = 1'b0;
    msb_in_beat_t  item   = '0;
    logic          busy;
    logic          strobe;
    msb_out_beat_t result;

    // sender idle chance in percent for the current phase
    int sender_idle_pct = 0;
    int mismatch_count  = 0;
    int idle_cycles     = 0;

    // current set as the block should hold it: ascending row, count, dropped flag
    logic signed [31:0] set_row [MSB_MAX_ITEMS];
    int                 set_count = 0;
    logic               set_lost  = 1'b0;

    // sorted beats still owed by the block, oldest first
    msb_out_beat_t sorted_beats [$];
    msb_out_beat_t owed_beat;

    merge_sort_buffer u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic log_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        end
    endtask

    // Insert a taken key into the predicted row; on the closing key, queue
    // the whole row as the expected burst and empty the set.
    task automatic take_key(input logic signed [31:0] key, input logic lst);
        int pos;
        msb_out_beat_t beat;
        if (set_count < MSB_MAX_ITEMS)
        begin
            pos = set_count;
            while (pos > 0 && set_row[pos-1] > key)
            begin
                set_row[pos] = set_row[pos-1];
                pos--;
            end
            set_row[pos] = key;
            set_count++;
        end
        else
        begin
            set_lost = 1'b1;   // buffer full: key dropped, set flagged
        end
        if (lst)
        begin
            for (int i = 0; i < set_count; i++)
            begin
                beat.key_out  = set_row[i];
                beat.last_out = (i == set_count - 1);
                beat.overflow = set_lost;
                sorted_beats.push_back(beat);
            end
            set_count = 0;
            set_lost  = 1'b0;
        end
    endtask

    // Present one key beat, with a random idle stretch ahead of it, and wait
    // for it to be taken. start stays high across back-to-back beats, so it
    // also sits high through a drain while busy is set.
    task automatic send_key(input logic signed [31:0] key, input logic lst);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        item.key_in  <= key;
        item.last_in <= lst;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        take_key(key, lst);
    endtask

    // Drop start and let the block finish the burst in flight.
    task automatic drain_results();
        start <= 1'b0;
        while (sorted_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_key();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(16) - 8;                      // many duplicates
            2:
            begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom_range(200 << 16) - (100 << 16); // +-100.0 in Q16.16
        endcase
    endfunction

    // one-key sets, including one whose key is the most negative value
    task automatic test_single_key_sets();
        send_key(32'sd0, 1'b1);
        send_key(32'h8000_0000, 1'b1);
        send_key(-32'sd1, 1'b1);
        drain_results();
    endtask

    // both extremes, duplicates, zero crossings and alternating bit patterns
    task automatic test_extreme_keys();
        send_key(32'h7FFF_FFFF, 1'b0);
        send_key(32'h8000_0000, 1'b0);
        send_key(32'h0000_0000, 1'b0);
        send_key(32'hFFFF_FFFF, 1'b0);
        send_key(32'h0000_0001, 1'b0);
        send_key(32'h5555_5555, 1'b0);
        send_key(32'hAAAA_AAAA, 1'b0);
        send_key(32'h8000_0000, 1'b0);
        send_key(32'h7FFF_FFFF, 1'b0);
        send_key(32'h0001_0000, 1'b0);
        send_key(32'hFFFF_0000, 1'b0);
        send_key(32'h0000_0000, 1'b1);
        // already ascending, then descending
        send_key(-32'sd3, 1'b0);
        send_key(32'sd2, 1'b0);
        send_key(32'sd9, 1'b1);
        send_key(32'sd9, 1'b0);
        send_key(32'sd2, 1'b0);
        send_key(-32'sd3, 1'b1);
        drain_results();
    endtask

    // the row fills completely, then keys past it are dropped, the closing
    // key among them; the next set must come out with the flag cleared
    task automatic test_overflow();
        for (int i = 0; i < MSB_MAX_ITEMS + 2; i++)
        begin
            send_key(rand_key(), i == MSB_MAX_ITEMS + 1);
        end
        send_key(rand_key(), 1'b0);
        send_key(rand_key(), 1'b1);
        drain_results();
    endtask

    // random well-formed sets, mostly very short, now and then longer
    task automatic test_random_sets(input int idle_pct, input int key_goal);
        int sent;
        int set_len;
        int pick;
        sender_idle_pct = idle_pct;
        sent = 0;
        while (sent < key_goal)
        begin
            pick = $urandom_range(99);
            if (pick < 90)
                set_len = $urandom_range(8, 1);
            else
                set_len = $urandom_range(16, 9);
            for (int i = 0; i < set_len; i++)
            begin
                send_key(rand_key(), i == set_len - 1);
            end
            sent += set_len;
        end
        drain_results();
        sender_idle_pct = 0;
    endtask

    // Result checker: every strobed beat against the oldest owed beat.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (sorted_beats.size() == 0)
            begin
                log_mismatch("unexpected beat", 32'h0, result.key_out);
            end
            else
            begin
                owed_beat = sorted_beats.pop_front();
                if (result.key_out !== owed_beat.key_out)
                    log_mismatch("key_out", owed_beat.key_out, result.key_out);
                if (result.last_out !== owed_beat.last_out)
                    log_mismatch("last_out", 32'(owed_beat.last_out),
                                 32'(result.last_out));
                if (result.overflow !== owed_beat.overflow)
                    log_mismatch("overflow", 32'(owed_beat.overflow),
                                 32'(result.overflow));
            end
        end
    end

    // Watchdog: a run with no beat taken on either side for too long is hung.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired at %0t", $time);
            $display("status: fail");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_key_sets();
        test_extreme_keys();
        test_overflow();
        // idle phases: none, heavy sender gaps, light sender gaps
        test_random_sets(0, 10);
        test_random_sets(84, 10);
        test_random_sets(17, 10);

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && sorted_beats.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
